[rtl/core/mhmm_pkg.sv]
// Package: sizes, status codes, controller states and command/status structs for the heap merger.
package mhmm_pkg;
  localparam int NUM_HEAPS  = 8;
  localparam int HEAP_DEPTH = 64;
  localparam int VALUE_BITS = 16;
  localparam int HW   = $clog2(NUM_HEAPS);
  localparam int PW   = $clog2(HEAP_DEPTH);
  localparam int SW   = $clog2(HEAP_DEPTH + 1);
  localparam int AW   = HW + PW;
  localparam int DEPTH_ALL = NUM_HEAPS * HEAP_DEPTH;

  localparam logic [1:0] ST_EXTRACTED = 2'd0;
  localparam logic [1:0] ST_LOADED    = 2'd1;
  localparam logic [1:0] ST_DROPPED   = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_BINIT, S_BNEXT, S_SRD_P, S_SRD_L, S_SRD_R, S_SCMP,
    S_SWAP, S_SWAP2, S_SCAN_RD, S_SCAN, S_EXT_RD, S_EXT_WR, S_OUT
  } state_t;

  typedef struct packed {
    logic latch_in;     // capture input transaction
    logic do_load;      // append or drop
    logic bld_init;     // start build at heap 0
    logic bld_next;     // advance build position
    logic sift_start_build;
    logic rd_pos;
    logic rd_left;
    logic rd_right;
    logic cap_pos;
    logic cap_left;
    logic cap_right;
    logic do_swap;      // write chosen child value into parent slot
    logic swap_wr;      // write old parent value into child slot
    logic scan_start;
    logic scan_step;
    logic ext_rd;
    logic ext_wr;
    logic set_built;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic req_ext;
    logic built;
    logic bld_done;     // all heaps built
    logic bld_skip;     // current build position not active
    logic has_left;
    logic has_right;
    logic need_swap;
    logic scan_last;
    logic in_build;
    logic any_found;
  } sts_t;
endpackage

[rtl/core/mhmm_if.sv]
// Interfaces: valid/ready channels for input and result transactions.
interface mhmm_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [2:0]  heap_index;
  logic [15:0] value;
  modport source (output valid, req_type, heap_index, value, input ready);
  modport sink   (input valid, req_type, heap_index, value, output ready);
endinterface

interface mhmm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] max_value;
  logic [2:0]  source_heap;
  logic        heap_finished;
  logic [2:0]  finish_rank;
  modport source (output valid, status, max_value, source_heap, heap_finished, finish_rank,
                  input ready);
  modport sink   (input valid, status, max_value, source_heap, heap_finished, finish_rank,
                  output ready);
endinterface

[rtl/core/multi_heap_max_merge.sv]
// Top level: multi-heap maximum extractor with valid/ready channels.
// Usage:
//   in channel carries req_type, heap_index and value. A load (req_type 0)
//   appends a value to one heap; a full heap or an index out of range drops it.
//   An extract (req_type 1) returns the largest root among non-empty heaps,
//   lowest heap index on ties, with heap_finished and finish_rank when that
//   heap empties; status 3 when all heaps are empty.
// Sequence:
//   A load is written in S_LOAD and its result is loaded in S_OUT. An
//   extract scans the heap roots in S_SCAN, moves the last element up in
//   S_EXT_RD and S_EXT_WR, then runs sift-down levels (S_SRD_P, S_SRD_L,
//   S_SRD_R, S_SCMP, S_SWAP, plus S_SWAP2 for a level that swaps) until it
//   stops, and S_OUT loads the result. The first extract after loads first
//   builds every heap: S_BINIT visits each candidate node and runs the same
//   sift for each interior node. The single storage RAM port sets the rate.
//   One transaction is in work at a time.
// Reset clears heap sizes, the built flag and the rank counter; no memory
//   clearing pass is needed. A stalled receiver holds the result register
//   and the block accepts a new transaction only once that slot is free.
module multi_heap_max_merge import mhmm_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  mhmm_in_if.sink   in_ch,
  mhmm_out_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;

  mhmm_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  mhmm_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_req_type(in_ch.req_type), .in_heap_index(in_ch.heap_index),
    .in_value(in_ch.value),
    .res_status(out_ch.status), .res_max_value(out_ch.max_value),
    .res_source_heap(out_ch.source_heap), .res_heap_finished(out_ch.heap_finished),
    .res_finish_rank(out_ch.finish_rank)
  );
endmodule

[rtl/core/mhmm_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
module mhmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/mhmm_dp.sv]
// Datapath: heap storage, sizes, sift-down registers, root scan and result register.
module mhmm_dp import mhmm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  output sts_t         sts,
  input  logic         in_req_type,
  input  logic [2:0]   in_heap_index,
  input  logic [15:0]  in_value,
  output logic [1:0]   res_status,
  output logic [15:0]  res_max_value,
  output logic [2:0]   res_source_heap,
  output logic         res_heap_finished,
  output logic [2:0]   res_finish_rank
);
  logic [SW-1:0]   size_r [NUM_HEAPS];
  logic            built_r;
  logic [2:0]      fcnt_r;
  logic            req_r;
  logic [2:0]      idx_r;
  logic [VALUE_BITS-1:0] val_r;
  logic            load_ok_r;
  // sift-down context
  logic [HW-1:0]   heap_r;
  logic [PW-1:0]   pos_r;
  logic [SW-1:0]   n_r;
  logic [VALUE_BITS-1:0] pv_r, lv_r, rv_r;
  logic            in_build_r;
  logic [SW-1:0]   bpos_r;        // build position + 1 (counts down)
  // root scan
  logic [HW-1:0]   scan_r;
  logic            found_r;
  logic [HW-1:0]   sel_r;
  logic [VALUE_BITS-1:0] top_r;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wdata, rdata;

  mhmm_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH_ALL)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [SW:0]   left_w, right_w;
  logic [PW-1:0] best_w;
  logic [VALUE_BITS-1:0] bestv_w;
  logic          take_l, take_r;
  logic          idx_ok;
  logic          ld_ok_w;
  logic [HW-1:0] idx_h;
  logic [SW-1:0] cur_sz;

  assign left_w  = {1'b0, pos_r, 1'b1};
  assign right_w = {1'b0, pos_r, 1'b0} + (SW+1)'(2);
  assign take_l  = sts.has_left && (lv_r > pv_r);
  assign take_r  = sts.has_right && (rv_r > (take_l ? lv_r : pv_r));
  assign best_w  = take_r ? right_w[PW-1:0] : left_w[PW-1:0];
  assign bestv_w = take_r ? rv_r : lv_r;
  assign idx_ok  = ({1'b0, idx_r} < 4'(NUM_HEAPS));
  assign idx_h   = HW'(idx_r);
  assign cur_sz  = size_r[idx_h];
  assign ld_ok_w = idx_ok && (cur_sz < SW'(HEAP_DEPTH));

  // status toward the controller
  always_comb begin
    sts.req_ext   = req_r;
    sts.built     = built_r;
    sts.bld_done  = (bpos_r == '0) && (heap_r == HW'(NUM_HEAPS - 1));
    sts.bld_skip  = (bpos_r == '0) || ({1'b0, bpos_r} > {1'b0, size_r[heap_r] >> 1} + 1'b1)
                    || ((SW+1)'(bpos_r) - 1'b1 >= (SW+1)'(size_r[heap_r]));
    sts.has_left  = left_w < (SW+1)'(n_r);
    sts.has_right = right_w < (SW+1)'(n_r);
    sts.need_swap = take_l || take_r;
    sts.scan_last = (scan_r == HW'(NUM_HEAPS - 1));
    sts.in_build  = in_build_r;
    sts.any_found = found_r;
  end

  // memory port steering
  always_comb begin
    we    = 1'b0;
    waddr = {heap_r, pos_r};
    wdata = bestv_w;
    raddr = {heap_r, pos_r};
    if (cmd.do_load) begin
      we    = ld_ok_w;
      waddr = {idx_h, cur_sz[PW-1:0]};
      wdata = val_r;
    end else if (cmd.do_swap) begin
      we    = 1'b1;
      waddr = {heap_r, pos_r};
      wdata = bestv_w;
    end else if (cmd.swap_wr) begin
      we    = 1'b1;
      waddr = {heap_r, pos_r};
      wdata = pv_r;
    end else if (cmd.ext_wr) begin
      we    = 1'b1;
      waddr = {sel_r, {PW{1'b0}}};
      wdata = rdata;
    end
    if (cmd.rd_pos)   raddr = {heap_r, pos_r};
    if (cmd.rd_left)  raddr = {heap_r, left_w[PW-1:0]};
    if (cmd.rd_right) raddr = {heap_r, right_w[PW-1:0]};
    if (cmd.scan_start || cmd.scan_step) raddr = {cmd.scan_start ? HW'(0) : scan_r + 1'b1,
                                                   {PW{1'b0}}};
    if (cmd.ext_rd) raddr = {sel_r, PW'(size_r[sel_r] - 1'b1)};
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_HEAPS; k++) size_r[k] <= '0;
      built_r <= 1'b0;
      fcnt_r  <= '0;
      found_r <= 1'b0;
      in_build_r <= 1'b0;
      res_status <= ST_EMPTY;
      res_max_value <= '0;
      res_source_heap <= '0;
      res_heap_finished <= 1'b0;
      res_finish_rank <= '0;
    end else begin
      if (cmd.latch_in) begin
        req_r <= in_req_type;
        idx_r <= in_heap_index;
        val_r <= VALUE_BITS'(in_value);
      end
      if (cmd.do_load) begin
        built_r   <= 1'b0;
        load_ok_r <= ld_ok_w;
        if (ld_ok_w) size_r[idx_h] <= cur_sz + 1'b1;
      end
      if (cmd.out_load) begin
        if (!req_r) begin
          res_status        <= load_ok_r ? ST_LOADED : ST_DROPPED;
          res_max_value     <= '0;
          res_source_heap   <= idx_r;
          res_heap_finished <= 1'b0;
          res_finish_rank   <= '0;
        end else if (!found_r) begin
          res_status        <= ST_EMPTY;
          res_max_value     <= '0;
          res_source_heap   <= '0;
          res_heap_finished <= 1'b0;
          res_finish_rank   <= '0;
        end else begin
          res_status        <= ST_EXTRACTED;
          res_max_value     <= 16'(top_r);
          res_source_heap   <= 3'(sel_r);
          res_heap_finished <= (size_r[sel_r] == '0);
          res_finish_rank   <= (size_r[sel_r] == '0) ? fcnt_r : 3'd0;
          if (size_r[sel_r] == '0) fcnt_r <= fcnt_r + 1'b1;
        end
      end
      if (cmd.set_built) built_r <= 1'b1;
      // build walk
      if (cmd.bld_init) begin
        heap_r <= '0;
        bpos_r <= SW'((size_r[0] >> 1) + 1'b1);
        in_build_r <= 1'b1;
      end
      if (cmd.bld_next) begin
        if (bpos_r == '0) begin
          heap_r <= heap_r + 1'b1;
          bpos_r <= SW'((size_r[HW'(heap_r + 1'b1)] >> 1) + 1'b1);
        end else begin
          bpos_r <= bpos_r - 1'b1;
        end
      end
      if (cmd.sift_start_build) begin
        pos_r <= PW'(bpos_r - 1'b1);
        n_r   <= size_r[heap_r];
      end
      if (cmd.cap_pos)   pv_r <= rdata;
      if (cmd.cap_left)  lv_r <= rdata;
      if (cmd.cap_right) rv_r <= rdata;
      // follow the displaced parent down into the chosen child
      if (cmd.do_swap) pos_r <= best_w;
      // root scan over heaps
      if (cmd.scan_start) begin
        scan_r  <= '0;
        found_r <= 1'b0;
        in_build_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (size_r[scan_r] != '0 && (!found_r || rdata > top_r)) begin
          found_r <= 1'b1;
          sel_r   <= scan_r;
          top_r   <= rdata;
        end
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.ext_rd) size_r[sel_r] <= size_r[sel_r] - 1'b1;
      if (cmd.ext_wr) begin
        heap_r <= sel_r;
        pos_r  <= '0;
        n_r    <= size_r[sel_r];
      end
    end
  end
endmodule

[rtl/core/mhmm_ctrl.sv]
// Controller: sequences load, heap build, root scan, extraction and sift-down.
module mhmm_ctrl import mhmm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = !ov_r || out_ready;
        if (in_valid && in_ready) begin
          cmd.latch_in = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!sts.req_ext) begin
          cmd.do_load = 1'b1;
          state_nxt = S_OUT;
        end else if (!sts.built) begin
          cmd.bld_init = 1'b1;
          state_nxt = S_BINIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_BINIT: begin
        if (sts.bld_skip) begin
          if (sts.bld_done) begin
            cmd.set_built = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            cmd.bld_next = 1'b1;
          end
        end else begin
          cmd.sift_start_build = 1'b1;
          cmd.bld_next = 1'b1;
          state_nxt = S_SRD_P;
        end
      end
      S_SRD_P: begin
        cmd.rd_pos = 1'b1;
        state_nxt = S_SRD_L;
      end
      S_SRD_L: begin
        cmd.cap_pos = 1'b1;
        cmd.rd_left = 1'b1;
        state_nxt = S_SRD_R;
      end
      S_SRD_R: begin
        cmd.cap_left = 1'b1;
        cmd.rd_right = 1'b1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        cmd.cap_right = 1'b1;
        state_nxt = S_SWAP;
      end
      S_SWAP: begin
        if (sts.need_swap) begin
          cmd.do_swap = 1'b1;
          state_nxt = S_SWAP2;
        end else if (sts.in_build) begin
          state_nxt = S_BINIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SWAP2: begin
        cmd.swap_wr = 1'b1;
        state_nxt = S_SRD_P;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_EXT_RD;
      end
      S_EXT_RD: begin
        if (sts.any_found) begin
          cmd.ext_rd = 1'b1;
          state_nxt = S_EXT_WR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_EXT_WR: begin
        cmd.ext_wr = 1'b1;
        state_nxt = S_SRD_P;
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> !in_ready;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r) else $error("result lost");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (state_r == S_OUT)) else $error("stray result");
endmodule

[tb/multi_heap_max_merge_test.sv]
// Testbench: drives load and extract transactions into the heap merger and checks every result.
`timescale 1ns / 1ps

module multi_heap_max_merge_test import mhmm_pkg::*;;

  localparam int RANDOM_ITEMS = 550;
  localparam int CALM_ITEMS   = 80;
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] max_value;
    logic [2:0]  source_heap;
    logic        heap_finished;
    logic [2:0]  finish_rank;
  } heap_result_t;

  typedef struct {
    logic         req_type;
    logic [2:0]   heap_index;
    logic [15:0]  value;
    bit           typed;
    heap_result_t result;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mhmm_in_if  in_ch ();
  mhmm_out_if out_ch ();

  multi_heap_max_merge DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow heaps of the predictor
  logic [VALUE_BITS-1:0] heap_mem [NUM_HEAPS][HEAP_DEPTH];
  int unsigned           heap_cnt [NUM_HEAPS];
  bit                    heaps_ready;
  logic [2:0]            rank_ctr;

  heap_result_t pending_results [$];
  int  errors;
  bit  calm;
  int  n_load, n_extract, n_drop, n_finish, n_empty;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Restore heap order below one node
  function automatic void sift_node(int k, int unsigned n, int unsigned pos);
    int unsigned best, left, right;
    logic [VALUE_BITS-1:0] t;
    forever begin
      best  = pos;
      left  = 2 * pos + 1;
      right = 2 * pos + 2;
      if (left < n && heap_mem[k][left] > heap_mem[k][best]) best = left;
      if (right < n && heap_mem[k][right] > heap_mem[k][best]) best = right;
      if (best == pos) return;
      t = heap_mem[k][pos];
      heap_mem[k][pos] = heap_mem[k][best];
      heap_mem[k][best] = t;
      pos = best;
    end
  endfunction

  // Compute the result of one accepted transaction and advance the shadow state
  function automatic heap_result_t heap_predict(logic req, logic [2:0] idx, logic [15:0] val);
    heap_result_t r;
    bit found;
    int sel;
    logic [VALUE_BITS-1:0] top;
    int unsigned n;
    r = '0;
    if (req == REQ_LOAD) begin
      heaps_ready = 1'b0;
      r.source_heap = idx;
      if (idx >= NUM_HEAPS || heap_cnt[idx] >= HEAP_DEPTH) begin
        r.status = ST_DROPPED;
        return r;
      end
      heap_mem[idx][heap_cnt[idx]] = val[VALUE_BITS-1:0];
      heap_cnt[idx]++;
      r.status = ST_LOADED;
      return r;
    end
    if (!heaps_ready) begin
      for (int k = 0; k < NUM_HEAPS; k++)
        for (int i = heap_cnt[k] / 2 + 1; i > 0; i--) sift_node(k, heap_cnt[k], i - 1);
      heaps_ready = 1'b1;
    end
    found = 1'b0;
    sel = 0;
    top = '0;
    for (int k = 0; k < NUM_HEAPS; k++) begin
      if (heap_cnt[k] != 0 && (!found || heap_mem[k][0] > top)) begin
        found = 1'b1;
        sel = k;
        top = heap_mem[k][0];
      end
    end
    if (!found) begin
      r.status = ST_EMPTY;
      return r;
    end
    n = heap_cnt[sel] - 1;
    heap_mem[sel][0] = heap_mem[sel][n];
    heap_cnt[sel] = n;
    sift_node(sel, n, 0);
    r.status = ST_EXTRACTED;
    r.max_value = 16'(top);
    r.source_heap = 3'(sel);
    if (n == 0) begin
      r.heap_finished = 1'b1;
      r.finish_rank = rank_ctr;
      rank_ctr = rank_ctr + 3'd1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  // Drive one transaction, hold it until accepted, then queue its result
  task automatic send_item(logic req, logic [2:0] idx, logic [15:0] val,
                           bit typed, heap_result_t typed_res);
    heap_result_t r;
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.req_type   = req;
    in_ch.heap_index = idx;
    in_ch.value      = val;
    do @(posedge clk); while (!in_ch.ready);
    r = heap_predict(req, idx, val);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 16'hFFFF;
      1: return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Result sink with random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  initial begin
    heap_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", out_ch.status, -1);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
          if (out_ch.max_value !== want.max_value)
            report_mismatch("max_value", out_ch.max_value, want.max_value);
          if (out_ch.source_heap !== want.source_heap)
            report_mismatch("source_heap", out_ch.source_heap, want.source_heap);
          if (out_ch.heap_finished !== want.heap_finished)
            report_mismatch("heap_finished", out_ch.heap_finished, want.heap_finished);
          if (out_ch.finish_rank !== want.finish_rank)
            report_mismatch("finish_rank", out_ch.finish_rank, want.finish_rank);
          case (want.status)
            ST_EXTRACTED: n_extract++;
            ST_LOADED:    n_load++;
            ST_DROPPED:   n_drop++;
            default:      n_empty++;
          endcase
          if (want.heap_finished) n_finish++;
        end
      end
    end
  end

  // Hard limit on run time
  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    stim_row_t directed [$];
    heap_result_t none;
    int nloads, nextr, sent, hsel;
    none = '0;
    errors = 0;
    calm = 1'b0;
    heaps_ready = 1'b0;
    rank_ctr = '0;
    for (int k = 0; k < NUM_HEAPS; k++) heap_cnt[k] = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_LOAD;
    in_ch.heap_index = '0;
    in_ch.value = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: empty after reset, extreme values, ties, ranks
    directed = '{
      '{REQ_EXTRACT, 3'd5, 16'hA5A5, 1, '{ST_EMPTY, 16'h0, 3'd0, 1'b0, 3'd0}},
      '{REQ_LOAD, 3'd0, 16'hFFFF, 1, '{ST_LOADED, 16'h0, 3'd0, 1'b0, 3'd0}},
      '{REQ_LOAD, 3'd7, 16'h0000, 1, '{ST_LOADED, 16'h0, 3'd7, 1'b0, 3'd0}},
      '{REQ_LOAD, 3'd7, 16'hFFFF, 1, '{ST_LOADED, 16'h0, 3'd7, 1'b0, 3'd0}},
      '{REQ_EXTRACT, 3'd7, 16'hFFFF, 1, '{ST_EXTRACTED, 16'hFFFF, 3'd0, 1'b1, 3'd0}},
      '{REQ_EXTRACT, 3'd0, 16'h0000, 1, '{ST_EXTRACTED, 16'hFFFF, 3'd7, 1'b0, 3'd0}},
      '{REQ_EXTRACT, 3'd2, 16'h1234, 1, '{ST_EXTRACTED, 16'h0000, 3'd7, 1'b1, 3'd1}},
      '{REQ_EXTRACT, 3'd1, 16'h5555, 1, '{ST_EMPTY, 16'h0, 3'd0, 1'b0, 3'd0}},
      '{REQ_LOAD, 3'd3, 16'h0010, 0, none},
      '{REQ_LOAD, 3'd3, 16'h8000, 0, none},
      '{REQ_LOAD, 3'd5, 16'h8000, 0, none},
      '{REQ_LOAD, 3'd3, 16'h0400, 0, none},
      '{REQ_LOAD, 3'd6, 16'h7FFF, 0, none},
      '{REQ_EXTRACT, 3'd0, 16'h0, 0, none},
      '{REQ_LOAD, 3'd5, 16'h9000, 0, none},
      '{REQ_EXTRACT, 3'd0, 16'h0, 0, none},
      '{REQ_EXTRACT, 3'd0, 16'h0, 0, none},
      '{REQ_EXTRACT, 3'd0, 16'h0, 0, none},
      '{REQ_EXTRACT, 3'd0, 16'h0, 0, none},
      '{REQ_EXTRACT, 3'd0, 16'h0, 0, none},
      '{REQ_EXTRACT, 3'd0, 16'h0, 0, none},
      '{REQ_EXTRACT, 3'd0, 16'h0, 0, none}
    };
    foreach (directed[i])
      send_item(directed[i].req_type, directed[i].heap_index, directed[i].value,
                directed[i].typed, directed[i].result);

    // Random load bursts followed by extract runs; now and then fill one heap past full
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 14) == 0) begin
        hsel = $urandom_range(0, NUM_HEAPS - 1);
        nloads = HEAP_DEPTH + $urandom_range(1, 4);
        for (int i = 0; i < nloads; i++)
          send_item(REQ_LOAD, 3'(hsel), 16'($urandom), 0, none);
      end else begin
        nloads = $urandom_range(1, 12);
        for (int i = 0; i < nloads; i++)
          send_item(REQ_LOAD, 3'($urandom), pick_value(), 0, none);
      end
      nextr = $urandom_range(0, nloads + 3);
      for (int i = 0; i < nextr; i++)
        send_item(REQ_EXTRACT, 3'($urandom), 16'($urandom), 0, none);
      sent += nloads + nextr;
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Covered %0d loads, %0d drops on full heaps, %0d extractions, %0d empty replies,",
             n_load, n_drop, n_extract, n_empty);
    $display("with %0d heaps run dry; %0d mismatches seen.", n_finish, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
